// File: rtl/hts_pkg.sv
// Package of the hexahedral shape function evaluator.
// Holds the request and result struct types, fixed constants and a rounding helper; no dependencies.
package hts_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int ONE_Q12 = 4096;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] xi;
		logic signed [COORD_WIDTH-1:0] eta;
		logic signed [COORD_WIDTH-1:0] zeta;
		logic                          last_point;
	} hts_in_t;

	typedef struct packed {
		logic [2:0]         node;
		logic signed [23:0] weight;
		logic signed [23:0] grad_xi;
		logic signed [23:0] grad_eta;
		logic signed [23:0] grad_zeta;
		logic               inside_res;
		logic [15:0]        outside_distance;
		logic               batch_end;
		logic               last_node;
	} hts_out_t;

	// Round a magnitude by sh bits, apply the sign and saturate to 24 bits.
	function automatic logic signed [23:0] hts_finish(input logic neg, input logic [63:0] p,
		input int sh);
		logic [63:0] m;
		m = (p + (64'd1 << (sh - 1))) >> sh;
		if (neg) begin
			hts_finish = (m > 64'd8388608) ? 24'sh800000 : 24'((~m) + 64'd1);
		end else begin
			hts_finish = (m > 64'd8388607) ? 24'sh7fffff : 24'(m);
		end
	endfunction

endpackage

// File: rtl/hex_trilinear_shape_eval_unit.sv
// Top level of the hexahedral trilinear shape function evaluator.
// Depends on hts_pkg for the request and result types.
//
// Each accepted request (one point) yields eight results, one per node, which the
// output sequencer emits as it walks the eight nodes. The point runs through a
// five-stage pipeline (factors and excess, factor products, per-node products,
// square root in sixteen one-bit steps, node sequencing), and the next point is
// taken while the previous one still emits.
module hex_trilinear_shape_eval_unit
	import hts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [7:0]             cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  hts_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output hts_out_t               out_data
);

	localparam int FW = COORD_WIDTH + 2;
	localparam int SQ = 16;

	logic [7:0] tol_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// Stage valid bits and a global advance that holds every stage before the node sequencer on a stall.
	logic v_s1, v_s2, v_s3, v_s4q;
	logic adv;

	// Stage 1: factors, magnitudes, excesses.
	logic [FW-1:0] mlo_s1 [3], mhi_s1 [3];
	logic          nlo_s1 [3], nhi_s1 [3];
	logic [16:0]   ex_s1 [3];
	logic          big_s1, inside_s1, last_s1;

	logic signed [COORD_WIDTH-1:0] cc [3];
	logic signed [FW-1:0] clo [3], chi [3];
	logic signed [FW:0]   lim_lo [3], lim_hi [3];
	logic [FW:0]          exw [3];
	logic                 ins [3];

	always_comb begin
		cc[0] = COORD_WIDTH'(in_data.xi);
		cc[1] = COORD_WIDTH'(in_data.eta);
		cc[2] = COORD_WIDTH'(in_data.zeta);
		for (int k = 0; k < 3; k++) begin
			clo[k] = FW'(ONE_Q12) - FW'(cc[k]);
			chi[k] = FW'(ONE_Q12) + FW'(cc[k]);
			lim_lo[k] = -(FW+1)'(ONE_Q12) - (FW+1)'({1'b0, tol_q});
			lim_hi[k] = (FW+1)'(ONE_Q12) + (FW+1)'({1'b0, tol_q});
			ins[k] = 1'b1;
			exw[k] = '0;
			if ((FW+1)'(cc[k]) < lim_lo[k]) begin
				ins[k] = 1'b0;
				exw[k] = (FW+1)'(-(FW+1)'(ONE_Q12) - (FW+1)'(cc[k]));
			end else if ((FW+1)'(cc[k]) > lim_hi[k]) begin
				ins[k] = 1'b0;
				exw[k] = (FW+1)'((FW+1)'(cc[k]) - (FW+1)'(ONE_Q12));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				nlo_s1[k] <= clo[k][FW-1];
				nhi_s1[k] <= chi[k][FW-1];
				mlo_s1[k] <= clo[k][FW-1] ? FW'(-clo[k]) : FW'(clo[k]);
				mhi_s1[k] <= chi[k][FW-1] ? FW'(-chi[k]) : FW'(chi[k]);
				ex_s1[k]  <= (exw[k] >= (FW+1)'(65536)) ? 17'd0 : 17'(exw[k]);
			end
			big_s1    <= (exw[0] >= (FW+1)'(65536)) || (exw[1] >= (FW+1)'(65536))
				|| (exw[2] >= (FW+1)'(65536));
			inside_s1 <= ins[0] & ins[1] & ins[2];
			last_s1   <= in_data.last_point;
		end
	end

	// Stage 2: pairwise products of the eta/zeta factors and squared excesses.
	logic [2*FW-1:0] pez_s2 [4];
	logic            nez_s2 [4];
	logic [FW-1:0]   mx_s2 [2];
	logic            nx_s2 [2];
	logic [FW-1:0]   me_s2 [2], mz_s2 [2];
	logic            ne_s2 [2], nz_s2 [2];
	logic [33:0]     sq_s2 [3];
	logic            big_s2, inside_s2, last_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 4; j++) begin
				pez_s2[j] <= (j[0] ? mhi_s1[1] : mlo_s1[1]) * (j[1] ? mhi_s1[2] : mlo_s1[2]);
				nez_s2[j] <= (j[0] ? nhi_s1[1] : nlo_s1[1]) ^ (j[1] ? nhi_s1[2] : nlo_s1[2]);
			end
			mx_s2[0] <= mlo_s1[0]; mx_s2[1] <= mhi_s1[0];
			nx_s2[0] <= nlo_s1[0]; nx_s2[1] <= nhi_s1[0];
			me_s2[0] <= mlo_s1[1]; me_s2[1] <= mhi_s1[1];
			ne_s2[0] <= nlo_s1[1]; ne_s2[1] <= nhi_s1[1];
			mz_s2[0] <= mlo_s1[2]; mz_s2[1] <= mhi_s1[2];
			nz_s2[0] <= nlo_s1[2]; nz_s2[1] <= nhi_s1[2];
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= 34'(ex_s1[k] * ex_s1[k]);
			end
			big_s2 <= big_s1; inside_s2 <= inside_s1; last_s2 <= last_s1;
		end
	end

	// Stage 3: all eight node results except the distance, plus the sum of squares.
	logic signed [23:0] w_s3 [8], gx_s3 [8], ge_s3 [8], gz_s3 [8];
	logic [31:0] sum_s3;
	logic        sat_s3, inside_s3, last_s3;

	function automatic logic [2:0] hts_sides(input int n);
		logic px, pe, pz;
		px = (n == 1) || (n == 2) || (n == 5) || (n == 6);
		pe = (n == 2) || (n == 3) || (n == 6) || (n == 7);
		pz = (n >= 4);
		hts_sides = {pz, pe, px};
	endfunction

	logic [3*FW-1:0] pw [8];
	logic [2*FW-1:0] pxz [8], pxe [8];
	logic [2:0]      sd [8];
	logic [35:0]     sumc;

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			sd[n]  = hts_sides(n);
			pw[n]  = pez_s2[{sd[n][2], sd[n][1]}] * mx_s2[sd[n][0]];
			pxz[n] = mx_s2[sd[n][0]] * mz_s2[sd[n][2]];
			pxe[n] = mx_s2[sd[n][0]] * me_s2[sd[n][1]];
		end
		sumc = 36'(sq_s2[0]) + 36'(sq_s2[1]) + 36'(sq_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 8; n++) begin
				if (pw[n] == '0) begin
					w_s3[n] <= '0;
				end else if (64'(pw[n]) > (64'd1 << 47)) begin
					w_s3[n] <= (nez_s2[{sd[n][2], sd[n][1]}] ^ nx_s2[sd[n][0]])
						? 24'sh800000 : 24'sh7fffff;
				end else begin
					w_s3[n] <= hts_finish(nez_s2[{sd[n][2], sd[n][1]}] ^ nx_s2[sd[n][0]],
						64'(pw[n]), 23);
				end
				gx_s3[n] <= (pez_s2[{sd[n][2], sd[n][1]}] == '0) ? 24'sd0 :
					hts_finish(nez_s2[{sd[n][2], sd[n][1]}] ^ !sd[n][0],
						64'(pez_s2[{sd[n][2], sd[n][1]}]), 11);
				ge_s3[n] <= (pxz[n] == '0) ? 24'sd0 :
					hts_finish(nx_s2[sd[n][0]] ^ nz_s2[sd[n][2]] ^ !sd[n][1], 64'(pxz[n]), 11);
				gz_s3[n] <= (pxe[n] == '0) ? 24'sd0 :
					hts_finish(nx_s2[sd[n][0]] ^ ne_s2[sd[n][1]] ^ !sd[n][2], 64'(pxe[n]), 11);
			end
			sum_s3    <= sumc[31:0];
			sat_s3    <= big_s2 || (sumc >= 36'h100000000);
			inside_s3 <= inside_s2; last_s3 <= last_s2;
		end
	end

	// Stage 4: integer square root, one result bit per pipeline step.
	logic [31:0] rem_q [SQ+1];
	logic [15:0] root_q [SQ+1];
	logic        sat_q [SQ+1];
	logic        vq [SQ+1];
	logic signed [23:0] w_q [SQ+1][8], gx_q [SQ+1][8], ge_q [SQ+1][8], gz_q [SQ+1][8];
	logic        ins_q [SQ+1], last_q [SQ+1];

	always_comb begin
		rem_q[0] = sum_s3; root_q[0] = '0; sat_q[0] = sat_s3; vq[0] = v_s3;
		w_q[0] = w_s3; gx_q[0] = gx_s3; ge_q[0] = ge_s3; gz_q[0] = gz_s3;
		ins_q[0] = inside_s3; last_q[0] = last_s3;
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		logic [15:0] trial;
		logic [31:0] tsq;
		assign trial = root_q[i] | (16'd1 << (SQ - 1 - i));
		assign tsq = 32'(trial) * 32'(trial);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vq[i+1] <= 1'b0;
			end else if (adv) begin
				vq[i+1] <= vq[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[i+1]  <= rem_q[i];
				root_q[i+1] <= (tsq <= rem_q[i]) ? trial : root_q[i];
				sat_q[i+1]  <= sat_q[i];
				w_q[i+1] <= w_q[i]; gx_q[i+1] <= gx_q[i];
				ge_q[i+1] <= ge_q[i]; gz_q[i+1] <= gz_q[i];
				ins_q[i+1] <= ins_q[i]; last_q[i+1] <= last_q[i];
			end
		end
	end
	assign v_s4q = vq[SQ];

	// Stage 5: node sequencer holding one point and emitting eight results.
	logic               hold_v_q;
	logic [2:0]         node_q;
	logic signed [23:0] hw_q [8], hgx_q [8], hge_q [8], hgz_q [8];
	logic               hins_q, hlast_q;
	logic [15:0]        hdist_q;
	logic               load;

	assign load = v_s4q && (!hold_v_q || (out_ready && node_q == 3'd7));
	assign adv  = !v_s4q || load;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			hold_v_q <= 1'b0; node_q <= '0;
		end else begin
			if (adv) begin
				v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			end
			if (load) begin
				hold_v_q <= 1'b1; node_q <= '0;
			end else if (hold_v_q && out_ready) begin
				node_q <= node_q + 3'd1;
				if (node_q == 3'd7) begin
					hold_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hw_q <= w_q[SQ]; hgx_q <= gx_q[SQ]; hge_q <= ge_q[SQ]; hgz_q <= gz_q[SQ];
			hins_q <= ins_q[SQ]; hlast_q <= last_q[SQ];
			hdist_q <= sat_q[SQ] ? 16'hffff : root_q[SQ];
		end
	end

	assign out_valid = hold_v_q;
	always_comb begin
		out_data.node             = node_q;
		out_data.weight           = hw_q[node_q];
		out_data.grad_xi          = hgx_q[node_q];
		out_data.grad_eta         = hge_q[node_q];
		out_data.grad_zeta        = hgz_q[node_q];
		out_data.inside_res       = hins_q;
		out_data.outside_distance = hdist_q;
		out_data.batch_end        = (node_q == 3'd7) && hlast_q;
		out_data.last_node        = (node_q == 3'd7);
	end

endmodule

// File: sim/tb_hex_trilinear_shape_eval_unit.sv
// Testbench of the hexahedral trilinear shape function evaluator.
// Drives points, predicts the eight node results of each and checks them in order.
// Depends on hts_pkg and hex_trilinear_shape_eval_unit.
module tb_hex_trilinear_shape_eval_unit;
	import hts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_POINTS = 350;

	typedef struct {
		hts_in_t  pt;
		logic     has_gold;
		hts_out_t gold;
	} point_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	hts_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	hts_out_t out_data;

	logic [7:0] tol_shadow = '0;
	hts_out_t node_results_q[$];
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	bit       calm_stretch = 1'b0;
	bit       timed_out = 1'b0;
	point_row_t directed_rows[$];

	hex_trilinear_shape_eval_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] mag(input longint a);
		return (a < 0) ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic signed [23:0] round_sat(input bit neg, input logic [63:0] p,
		input int sh);
		logic [63:0] m;
		m = (p + (64'd1 << (sh - 1))) >> sh;
		if (neg) begin
			return (m > 64'd8388608) ? -24'sd8388608 : 24'(-longint'(m));
		end
		return (m > 64'd8388607) ? 24'sd8388607 : 24'(m);
	endfunction

	function automatic logic signed [23:0] trilinear_weight(input longint a, input longint b,
		input longint c);
		bit neg;
		logic [63:0] p;
		neg = ((a < 0) ^ (b < 0)) ^ (c < 0);
		p = mag(a) * mag(b);
		if (p == 0 || mag(c) == 0) begin
			return '0;
		end
		if (p > (64'd1 << 47) / mag(c)) begin
			return neg ? -24'sd8388608 : 24'sd8388607;
		end
		return round_sat(neg, p * mag(c), 23);
	endfunction

	function automatic logic signed [23:0] face_gradient(input bit negsign, input longint a,
		input longint b);
		logic [63:0] p;
		p = mag(a) * mag(b);
		if (p == 0) begin
			return '0;
		end
		return round_sat(((a < 0) ^ (b < 0)) ^ negsign, p, 11);
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic predict_node_results(input hts_in_t pt);
		longint c[3];
		longint lo[3];
		longint hi[3];
		longint ex;
		longint tol;
		bit in_cube;
		bit big;
		logic [63:0] sum;
		logic [15:0] distance;
		hts_out_t r;
		bit px, pe, pz;
		longint fx, fe, fz;
		c[0] = pt.xi;
		c[1] = pt.eta;
		c[2] = pt.zeta;
		tol = tol_shadow;
		in_cube = 1'b1;
		big = 1'b0;
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			lo[k] = ONE_Q12 - c[k];
			hi[k] = ONE_Q12 + c[k];
			ex = 0;
			if (c[k] < -ONE_Q12 - tol) begin
				ex = -ONE_Q12 - c[k];
				in_cube = 1'b0;
			end else if (c[k] > ONE_Q12 + tol) begin
				ex = c[k] - ONE_Q12;
				in_cube = 1'b0;
			end
			if (ex >= 65536) begin
				big = 1'b1;
			end else begin
				sum += 64'(ex * ex);
			end
		end
		if (big || sum >= 64'h1_0000_0000) begin
			distance = 16'hffff;
		end else begin
			distance = 16'(floor_sqrt(sum));
		end
		for (int n = 0; n < 8; n++) begin
			px = (n == 1 || n == 2 || n == 5 || n == 6);
			pe = (n == 2 || n == 3 || n == 6 || n == 7);
			pz = (n >= 4);
			fx = px ? hi[0] : lo[0];
			fe = pe ? hi[1] : lo[1];
			fz = pz ? hi[2] : lo[2];
			r.node = 3'(n);
			r.weight = trilinear_weight(fx, fe, fz);
			r.grad_xi = face_gradient(!px, fe, fz);
			r.grad_eta = face_gradient(!pe, fx, fz);
			r.grad_zeta = face_gradient(!pz, fx, fe);
			r.inside_res = in_cube;
			r.outside_distance = distance;
			r.batch_end = (n == 7) ? pt.last_point : 1'b0;
			r.last_node = (n == 7);
			node_results_q.push_back(r);
		end
	endtask

	task automatic send_point(input hts_in_t pt);
		while (!calm_stretch && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pt;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_node_results(pt);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (node_results_q.size() != 0 && !timed_out) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [7:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tol_shadow = v;
	endtask

	function automatic logic signed [15:0] random_coord();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6) begin
			return 16'($signed($urandom_range(8192)) - 4096);
		end else if (sel < 8) begin
			return 16'($signed($urandom_range(1024)) + (($urandom_range(1)) ? 3584 : -4608));
		end
		return 16'($urandom);
	endfunction

	function automatic point_row_t row(input int x, input int e, input int z, input bit lp);
		point_row_t t;
		t.pt.xi = 16'(x);
		t.pt.eta = 16'(e);
		t.pt.zeta = 16'(z);
		t.pt.last_point = lp;
		t.has_gold = 1'b0;
		t.gold = '0;
		return t;
	endfunction

	always @(posedge clk) begin
		hts_out_t gold;
		if (out_valid && out_ready) begin
			if (node_results_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected result %p", out_data);
				end
			end else begin
				gold = node_results_q.pop_front();
				if (out_data !== gold) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch: expected %p, actual %p", gold, out_data);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= calm_stretch || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				timed_out = 1'b1;
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		point_row_t t;
		hts_in_t pt;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		t = row(0, 0, 0, 1'b1);
		t.has_gold = 1'b1;
		t.gold = '{3'd0, 24'sd8192, -24'sd8192, -24'sd8192, -24'sd8192, 1'b1, 16'd0,
			1'b0, 1'b0};
		directed_rows.push_back(t);
		t = row(-4096, -4096, -4096, 1'b0);
		t.has_gold = 1'b1;
		t.gold = '{3'd0, 24'sd65536, -24'sd32768, -24'sd32768, -24'sd32768, 1'b1, 16'd0,
			1'b0, 1'b0};
		directed_rows.push_back(t);
		directed_rows.push_back(row(4096, 4096, 4096, 1'b1));
		directed_rows.push_back(row(4097, 0, 0, 1'b0));
		directed_rows.push_back(row(-4097, 0, 0, 1'b0));
		directed_rows.push_back(row(32767, 32767, 32767, 1'b1));
		directed_rows.push_back(row(-32768, -32768, -32768, 1'b0));
		directed_rows.push_back(row(32767, -32768, 32767, 1'b1));
		directed_rows.push_back(row(-32768, 32767, 0, 1'b0));
		directed_rows.push_back(row(8192, 8192, 8192, 1'b0));
		directed_rows.push_back(row(1234, -2345, 3456, 1'b1));
		directed_rows.push_back(row(0, 12288, -4096, 1'b0));

		foreach (directed_rows[i]) begin
			send_point(directed_rows[i].pt);
			if (directed_rows[i].has_gold) begin
				node_results_q[node_results_q.size() - 8] = directed_rows[i].gold;
			end
		end

		write_tolerance(8'd255);
		t = row(4096 + 255, -4096 - 255, 0, 1'b0);
		send_point(t.pt);
		t = row(4096 + 256, -4096 - 256, 0, 1'b1);
		send_point(t.pt);
		t = row(32767, -32768, 5000, 1'b0);
		send_point(t.pt);
		write_tolerance(8'd1);
		t = row(4097, -4097, 4098, 1'b1);
		send_point(t.pt);
		write_tolerance(8'd0);

		for (int i = 0; i < RANDOM_POINTS; i++) begin
			if (i == 100) begin
				write_tolerance(8'($urandom));
			end else if (i == 200) begin
				write_tolerance(8'd255);
			end else if (i == 280) begin
				write_tolerance(8'($urandom));
			end
			calm_stretch = (i >= 150 && i < 190);
			pt.xi = random_coord();
			pt.eta = random_coord();
			pt.zeta = random_coord();
			pt.last_point = 1'($urandom);
			send_point(pt);
		end
		calm_stretch = 1'b0;

		drain_results();
		if (mismatch_count == 0 && !timed_out) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
